// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the key scanner checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key scanner check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key scanner check failed");

`endif

// ===== rtl/core/mfks_pkg.sv =====
// ----------------------------------------------------------------------------
// mfks_pkg
// Types, constants and entry tables of the multi-function key scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfks_pkg;

    localparam int NUM_ENTRIES  = 5;
    localparam int NUM_KEY_BITS = 4;
    localparam int COUNT_WIDTH  = 16;

    localparam int ENTRY_W   = $clog2(NUM_ENTRIES + 1);
    localparam int IDX_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int KEY_IDX_W = 3;
    localparam int KIND_W    = 3;
    localparam int SHORT_W   = 8;
    localparam int LONG_W    = 16;
    localparam int CMP_W     = ((COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W) + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ENTRY_W-1:0] NO_ENTRY = ENTRY_W'(NUM_ENTRIES);

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_BASE   = 3'd3;

    localparam logic [SHORT_W-1:0] SHORT_DELAY_RST = 8'd3;
    localparam logic [SHORT_W-1:0] REPEAT_INT_RST  = 8'd20;
    localparam logic [SHORT_W-1:0] DOUBLE_WIN_RST  = 8'd30;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE   = 3'd0,
        EV_SHORT  = 3'd1,
        EV_LONG   = 3'd2,
        EV_REPEAT = 3'd3,
        EV_DOUBLE = 3'd4
    } t_event;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]  hold_count;
        logic                    press_valid;
        logic [NUM_KEY_BITS-1:0] last_pattern;
        logic [ENTRY_W-1:0]      active_entry;
    } t_press_state;

    typedef struct packed {
        t_press_state nxt;
        t_event       kind;
        logic         win_open;
        logic         win_close;
    } t_press_res;

    function automatic logic [NUM_KEY_BITS-1:0] entry_pattern(logic [ENTRY_W-1:0] e);
        logic [NUM_KEY_BITS-1:0] p;
        unique case (e)
            3'd0:    p = NUM_KEY_BITS'(1);
            3'd1:    p = NUM_KEY_BITS'(2);
            3'd2:    p = NUM_KEY_BITS'(4);
            3'd3:    p = NUM_KEY_BITS'(8);
            3'd4:    p = NUM_KEY_BITS'(3);
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic can_long(logic [ENTRY_W-1:0] e);
        return (e <= ENTRY_W'(3));
    endfunction

    function automatic logic can_repeat(logic [ENTRY_W-1:0] e);
        return (e == ENTRY_W'(0));
    endfunction

    function automatic logic can_double(logic [ENTRY_W-1:0] e);
        return (e <= ENTRY_W'(1));
    endfunction

    function automatic logic [LONG_W-1:0] long_reset(logic [ENTRY_W-1:0] e);
        logic [LONG_W-1:0] v;
        unique case (e)
            3'd0:    v = 16'd200;
            3'd1:    v = 16'd250;
            default: v = 16'd300;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mfks_press.sv =====
// ----------------------------------------------------------------------------
// mfks_press
// Debounce, entry match and short, long, repeat and double-click decisions
// for one scan tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfks_press
    import mfks_pkg::*;
(
    input  logic [NUM_KEY_BITS-1:0] i_bits,
    input  t_press_state            i_state,
    input  logic [SHORT_W-1:0]      i_short_delay,
    input  logic [SHORT_W-1:0]      i_repeat_interval,
    input  logic [LONG_W-1:0]       i_long_count,
    input  logic                    i_pending,
    output t_press_res              o_res
);

    logic [COUNT_WIDTH-1:0]  hc;
    logic [NUM_KEY_BITS-1:0] lp;
    logic                    pv;
    logic [ENTRY_W-1:0]      ae;
    logic [ENTRY_W-1:0]      id;
    logic [CMP_W-1:0]        sd_x;
    logic [CMP_W-1:0]        lc_x;
    logic [CMP_W-1:0]        rep_sum;
    logic                    ae_ok;

    assign sd_x    = CMP_W'(i_short_delay);
    assign lc_x    = CMP_W'(i_long_count);
    assign rep_sum = lc_x + CMP_W'(i_repeat_interval);
    assign ae_ok   = (i_state.active_entry < NO_ENTRY);

    always_comb begin
        id = NO_ENTRY;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (entry_pattern(ENTRY_W'(i)) == i_bits) begin
                id = ENTRY_W'(i);
            end
        end
    end

    always_comb begin
        hc = i_state.hold_count;
        lp = i_state.last_pattern;
        pv = i_state.press_valid;
        ae = i_state.active_entry;
        o_res.kind      = EV_NONE;
        o_res.win_open  = 1'b0;
        o_res.win_close = 1'b0;
        if (i_bits != '0) begin
            if (!pv) begin
                if (hc == '0) begin
                    lp = i_bits;
                end else if (lp != i_bits) begin
                    lp = i_bits;
                    hc = '0;
                end
                if (CMP_W'(hc) < sd_x) begin
                    hc = hc + COUNT_WIDTH'(1);
                end
                if (CMP_W'(hc) == sd_x) begin
                    pv = 1'b1;
                    ae = id;
                end else begin
                    ae = NO_ENTRY;
                end
            end else if (ae_ok) begin
                hc = hc + COUNT_WIDTH'(1);
                if (i_bits == lp && CMP_W'(hc) != sd_x) begin
                    if (CMP_W'(hc) == lc_x) begin
                        if (can_long(ae)) begin
                            o_res.kind = EV_LONG;
                        end
                    end else if (rep_sum == CMP_W'(hc)) begin
                        hc = COUNT_WIDTH'(i_long_count);
                        if (can_repeat(ae)) begin
                            o_res.kind = EV_REPEAT;
                        end
                    end
                end
            end
        end else begin
            if (pv && ae_ok && CMP_W'(hc) < lc_x) begin
                if (can_double(ae)) begin
                    if (i_pending) begin
                        o_res.win_close = 1'b1;
                        o_res.kind      = EV_DOUBLE;
                    end else begin
                        o_res.win_open = 1'b1;
                    end
                end else begin
                    o_res.kind = EV_SHORT;
                end
            end
            hc = '0;
            pv = 1'b0;
            lp = '0;
        end
        o_res.nxt.hold_count   = hc;
        o_res.nxt.press_valid  = pv;
        o_res.nxt.last_pattern = lp;
        o_res.nxt.active_entry = ae;
    end

endmodule

// ===== rtl/core/multi_function_key_scanner.sv =====
// ----------------------------------------------------------------------------
// multi_function_key_scanner
// Scan-tick key scanner giving short, long, repeat and double-click events.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  scan      in         i_valid / o_ready    i_key_bits
//  event     out        o_valid / i_ready    o_event_kind, o_key_index
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A request passes through S_EVAL and then S_DONE, and through S_WALK between
// them when the press gives no event and a double-click window is running or
// opens; the window timers are then walked, one timer per cycle through a single
// decrement-and-compare unit. The next request is taken while the last event
// still waits in the output register; a new event waits until that register is
// free. Reset is synchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_function_key_scanner
    import mfks_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [NUM_KEY_BITS-1:0] i_key_bits,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [KIND_W-1:0]       o_event_kind,
    output logic [KEY_IDX_W-1:0]    o_key_index,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [NUM_KEY_BITS-1:0] r_bits;
    logic [SHORT_W-1:0]      r_short_delay;
    logic [SHORT_W-1:0]      r_repeat_interval;
    logic [SHORT_W-1:0]      r_double_window;
    logic [LONG_W-1:0]       r_long_count [NUM_ENTRIES];
    t_press_state            r_press;
    logic                    r_pending [NUM_ENTRIES];
    logic [SHORT_W-1:0]      r_timer [NUM_ENTRIES];
    logic                    r_running;
    logic [IDX_W-1:0]        r_walk;
    logic                    r_found;
    logic                    r_any;
    t_event                  r_kind;
    logic [KEY_IDX_W-1:0]    r_idx;
    logic                    r_out_valid;
    logic [KIND_W-1:0]       r_out_kind;
    logic [KEY_IDX_W-1:0]    r_out_idx;

    logic                    ae_ok;
    logic [IDX_W-1:0]        ae_idx;
    logic [LONG_W-1:0]       lc_sel;
    logic                    pend_sel;
    t_press_res              press_res;
    logic [SHORT_W-1:0]      tmr_cur;
    logic [SHORT_W-1:0]      tmr_dec;
    logic                    do_dec;
    logic [SHORT_W-1:0]      tmr_after;
    logic                    n_any;
    logic                    walk_last;
    logic [CFG_IDX_W-1:0]    long_sel;
    logic                    out_free;

    assign ae_ok    = (r_press.active_entry < NO_ENTRY);
    assign ae_idx   = r_press.active_entry[IDX_W-1:0];
    assign lc_sel   = ae_ok ? r_long_count[ae_idx] : '0;
    assign pend_sel = ae_ok ? r_pending[ae_idx] : 1'b0;

    mfks_press u_press (
        .i_bits            (r_bits),
        .i_state           (r_press),
        .i_short_delay     (r_short_delay),
        .i_repeat_interval (r_repeat_interval),
        .i_long_count      (lc_sel),
        .i_pending         (pend_sel),
        .o_res             (press_res)
    );

    assign tmr_cur   = r_timer[r_walk];
    assign tmr_dec   = tmr_cur - SHORT_W'(1);
    assign do_dec    = !r_found && (tmr_cur != '0);
    assign tmr_after = do_dec ? tmr_dec : tmr_cur;
    assign n_any     = r_any | (tmr_after != '0);
    assign walk_last = (r_walk == IDX_W'(NUM_ENTRIES - 1));
    assign long_sel  = i_cfg_idx - REG_LONG_BASE;
    assign out_free  = !r_out_valid || i_ready;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_key_index  = r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_delay     <= SHORT_DELAY_RST;
            r_repeat_interval <= REPEAT_INT_RST;
            r_double_window   <= DOUBLE_WIN_RST;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_long_count[i] <= long_reset(ENTRY_W'(i));
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHORT_DELAY: r_short_delay     <= i_cfg_data[SHORT_W-1:0];
                REG_REPEAT_INT:  r_repeat_interval <= i_cfg_data[SHORT_W-1:0];
                REG_DOUBLE_WIN:  r_double_window   <= i_cfg_data[SHORT_W-1:0];
                default: begin
                    if (CFG_IDX_W'(long_sel) < CFG_IDX_W'(NUM_ENTRIES)) begin
                        r_long_count[long_sel[IDX_W-1:0]] <= i_cfg_data[LONG_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= S_IDLE;
            r_press.hold_count   <= '0;
            r_press.press_valid  <= 1'b0;
            r_press.last_pattern <= '0;
            r_press.active_entry <= NO_ENTRY;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_pending[i] <= 1'b0;
                r_timer[i]   <= '0;
            end
            r_running   <= 1'b0;
            r_walk      <= '0;
            r_found     <= 1'b0;
            r_any       <= 1'b0;
            r_kind      <= EV_NONE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_bits  <= i_key_bits;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_press <= press_res.nxt;
                    r_kind  <= press_res.kind;
                    r_idx   <= (press_res.kind == EV_NONE) ? '0 :
                               KEY_IDX_W'(r_press.active_entry);
                    if (press_res.win_open) begin
                        r_pending[ae_idx] <= 1'b1;
                        r_timer[ae_idx]   <= r_double_window;
                    end
                    if (press_res.win_close) begin
                        r_pending[ae_idx] <= 1'b0;
                        r_timer[ae_idx]   <= '0;
                    end
                    r_walk  <= '0;
                    r_found <= 1'b0;
                    r_any   <= 1'b0;
                    if (press_res.kind == EV_NONE &&
                        (r_running || press_res.win_open)) begin
                        r_running <= 1'b1;
                        r_state   <= S_WALK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_WALK: begin
                    if (do_dec) begin
                        r_timer[r_walk] <= tmr_dec;
                        if (tmr_dec == '0) begin
                            r_pending[r_walk] <= 1'b0;
                            r_found           <= 1'b1;
                            r_kind            <= EV_SHORT;
                            r_idx             <= KEY_IDX_W'(r_walk);
                        end
                    end
                    r_any  <= n_any;
                    r_walk <= r_walk + IDX_W'(1);
                    if (walk_last) begin
                        r_running <= n_any;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_idx   <= r_idx;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/mfks_checker.sv =====
// ----------------------------------------------------------------------------
// mfks_checker
// Port-level checks of the key scanner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfks_checker
    import mfks_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    o_ready,
    input  logic                    o_valid,
    input  logic                    i_ready,
    input  logic [KIND_W-1:0]       o_event_kind,
    input  logic [KEY_IDX_W-1:0]    o_key_index
);

    logic stalled;
    logic fields_ok;

    assign stalled   = o_valid && !i_ready;
    assign fields_ok = (o_key_index < KEY_IDX_W'(NUM_ENTRIES)) && (o_event_kind <= EV_DOUBLE);

    // A stalled event holds its value until it is taken.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, stalled, o_valid && $stable({o_event_kind, o_key_index}))

    // The scanner is busy in the cycle after it takes a request.
    `CHK_NEXT(a_busy_after_req, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // An empty event carries entry zero, and a real event names a real entry.
    `CHK_SAME(a_none_idx, i_clk, i_rst_n, o_valid && o_event_kind == EV_NONE, o_key_index == '0)
    `CHK_SAME(a_idx_range, i_clk, i_rst_n, o_valid, fields_ok)

    // Only key one repeats.
    `CHK_SAME(a_repeat_key, i_clk, i_rst_n, o_valid && o_event_kind == EV_REPEAT, o_key_index == '0)

endmodule

bind multi_function_key_scanner mfks_checker u_mfks_checker (.*);
